// ===== hdl/okc_pkg.sv =====
// shared widths, CSR indices and request mode codes for the k-core peeling block
`timescale 1ns / 1ps
`default_nettype none
package okc_pkg;
   localparam int CfgWidth  = 11;
   localparam int NodeWidth = 10;
   localparam int EdgeWidth = 12;
   localparam logic CSR_MIN_DEGREE = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_REPORT = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/offline_k_core_edge_deletion.sv =====
// top level: edge store, degree table and peeling sequencer
//
// usage
//    req_ channel takes one word per edge (mode 0) or a report request (mode 1)
//    rsp_ channel returns one word per report: core size, prefix end, status
//    csr_ channel writes min_degree (index 0) and node_count (index 1); the user
//    must write only while idle, which the block does not enforce
//    a load is taken while req_stall is low and loads can follow back to back
//    the first report runs a build pass: it clears the degree table and sets
//    the alive table for each node, then reads every stored edge and adds each
//    live edge to the degree of both ends; each report then runs peeling rounds;
//    each round visits every active node, and for each node peeled scans the
//    edge memory and drops its live edges; rounds repeat until one peels nothing
//    the result is registered after the last round, then the latest edge leaves
//    the prefix and, if live, is deleted; with no edges left the result is
//    registered with no peeling; each memory serves one access per cycle
// reset and stall
//    reset clears the edge count and report state; the first report rebuilds
//    the degree and alive tables; req_stall stays high while the sequencer runs
//    and until the registered result has been taken
`timescale 1ns / 1ps
`default_nettype none
module offline_k_core_edge_deletion #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [okc_pkg::NodeWidth-1:0] req_node_a,
   input  wire logic [okc_pkg::NodeWidth-1:0] req_node_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [okc_pkg::CfgWidth-1:0]       rsp_core_size,
   output logic [okc_pkg::EdgeWidth-1:0]      rsp_prefix_end,
   output logic                               rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [okc_pkg::CfgWidth-1:0]  csr_data
);
   import okc_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int VW = $clog2(MAX_NODES + 1);
   localparam int DW = CW + 1;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_BCLR   = 5'd1;
   localparam logic [4:0] S_BRD    = 5'd2;
   localparam logic [4:0] S_BCHK   = 5'd3;
   localparam logic [4:0] S_BDA    = 5'd4;
   localparam logic [4:0] S_BDB    = 5'd5;
   localparam logic [4:0] S_PRD    = 5'd6;
   localparam logic [4:0] S_PCHK   = 5'd7;
   localparam logic [4:0] S_ERD    = 5'd8;
   localparam logic [4:0] S_ECHK   = 5'd9;
   localparam logic [4:0] S_DA     = 5'd10;
   localparam logic [4:0] S_DB     = 5'd11;
   localparam logic [4:0] S_PNEXT  = 5'd12;
   localparam logic [4:0] S_LRD    = 5'd13;
   localparam logic [4:0] S_LCHK   = 5'd14;
   localparam logic [4:0] S_OUT    = 5'd15;
   localparam logic [4:0] S_PRD2   = 5'd16;
   localparam logic [4:0] S_DA2    = 5'd17;
   localparam logic [4:0] S_DB2    = 5'd18;

   logic [NodeWidth-1:0] efirst_mem  [MAX_EDGES];
   logic [NodeWidth-1:0] esecond_mem [MAX_EDGES];
   logic                 elive_mem   [MAX_EDGES];
   logic [DW-1:0]        deg_mem     [MAX_NODES];
   logic                 alive_mem   [MAX_NODES];

   logic [4:0]           state_ff, state_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [VW-1:0]        alive_cnt_ff, alive_cnt_in;
   logic [VW-1:0]        active_ff, active_in;
   logic                 started_ff, started_in;
   logic                 changed_ff, changed_in;
   logic [CfgWidth-1:0]  min_deg_ff;
   logic [CfgWidth-1:0]  node_cnt_ff;
   logic [VW-1:0]        vi_ff, vi_in;
   logic [CW-1:0]        ji_ff, ji_in;
   logic                 delete_ff, delete_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CfgWidth-1:0]  rsp_size_ff, rsp_size_in;
   logic [EdgeWidth-1:0] rsp_end_ff, rsp_end_in;
   logic                 rsp_status_ff, rsp_status_in;

   // memory ports
   logic [EW-1:0]        e_addr;
   logic                 e_we, el_we, el_wd;
   logic [NodeWidth-1:0] ea_q, eb_q;
   logic                 el_q;
   logic [NW-1:0]        n_addr;
   logic                 d_we, a_we, a_wd;
   logic [DW-1:0]        d_wd, d_q;
   logic                 a_q;

   always_ff @(posedge clock) begin
      if (e_we) begin
         efirst_mem[e_addr]  <= req_node_a;
         esecond_mem[e_addr] <= req_node_b;
      end
      if (el_we) elive_mem[e_addr] <= el_wd;
      ea_q <= efirst_mem[e_addr];
      eb_q <= esecond_mem[e_addr];
      el_q <= elive_mem[e_addr];
   end

   always_ff @(posedge clock) begin
      if (d_we) deg_mem[n_addr] <= d_wd;
      if (a_we) alive_mem[n_addr] <= a_wd;
      d_q <= deg_mem[n_addr];
      a_q <= alive_mem[n_addr];
   end

   logic req_take, rsp_take;
   logic [VW-1:0] nc_clip;
   logic [VW:0]   ea_ext, eb_ext;
   logic          a_ok, b_ok;
   logic [NodeWidth-1:0] cur_node;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign nc_clip   = ({1'b0, node_cnt_ff} > (CfgWidth+1)'(MAX_NODES)) ?
                      VW'(MAX_NODES) : VW'(node_cnt_ff);
   assign ea_ext    = (VW+1)'(ea_q);
   assign eb_ext    = (VW+1)'(eb_q);
   assign a_ok      = ea_ext < (VW+1)'(active_ff);
   assign b_ok      = eb_ext < (VW+1)'(active_ff);
   assign cur_node  = NodeWidth'(vi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_deg_ff  <= '0;
         node_cnt_ff <= CfgWidth'(1024);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MIN_DEGREE) min_deg_ff <= csr_data;
         else node_cnt_ff <= csr_data;
      end
   end

   always_comb begin
      state_in = state_ff; total_in = total_ff; ptr_in = ptr_ff;
      alive_cnt_in = alive_cnt_ff; active_in = active_ff; started_in = started_ff;
      changed_in = changed_ff; vi_in = vi_ff; ji_in = ji_ff; delete_in = delete_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_size_in = rsp_size_ff; rsp_end_in = rsp_end_ff; rsp_status_in = rsp_status_ff;
      e_addr = EW'(ji_ff); e_we = 1'b0; el_we = 1'b0; el_wd = 1'b0;
      n_addr = NW'(vi_ff); d_we = 1'b0; d_wd = d_q; a_we = 1'b0; a_wd = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_mode == MODE_LOAD) begin
                  if (!started_ff && total_ff < CW'(MAX_EDGES)) begin
                     e_addr = EW'(total_ff); e_we = 1'b1;
                     total_in = total_ff + 1'b1;
                  end
               end else if (!started_ff) begin
                  started_in = 1'b1; active_in = nc_clip; alive_cnt_in = nc_clip;
                  ptr_in = total_ff; vi_in = '0; state_in = S_BCLR;
               end else begin
                  state_in = S_LCHK;
               end
            end
         end
         S_BCLR: begin
            d_we = 1'b1; d_wd = '0; a_we = 1'b1; a_wd = vi_ff < active_ff;
            if (vi_ff == VW'(MAX_NODES - 1)) begin
               ji_in = '0; state_in = (total_ff == '0) ? S_LCHK : S_BRD;
            end
            vi_in = vi_ff + 1'b1;
         end
         S_BRD: state_in = S_BCHK;
         S_BCHK: begin
            el_we = 1'b1; el_wd = a_ok && b_ok && (ea_q != eb_q);
            if (el_wd) begin
               n_addr = NW'(ea_q); state_in = S_BDA;
            end else if (ji_ff + 1'b1 == total_ff) state_in = S_LCHK;
            else begin
               ji_in = ji_ff + 1'b1; state_in = S_BRD;
            end
         end
         S_BDA: begin
            n_addr = NW'(ea_q); d_we = 1'b1; d_wd = d_q + 1'b1;
            state_in = S_BDB;
         end
         S_BDB: begin
            n_addr = NW'(eb_q); state_in = S_DB2; delete_in = 1'b0;
         end
         S_DB2: begin
            n_addr = NW'(eb_q); d_we = 1'b1;
            d_wd = delete_ff ? ((d_q != '0) ? d_q - 1'b1 : d_q) : d_q + 1'b1;
            if (delete_ff && vi_ff == VW'(MAX_NODES)) state_in = S_IDLE;
            else if (ji_ff + 1'b1 == total_ff) state_in = delete_ff ? S_PNEXT : S_LCHK;
            else begin
               ji_in = ji_ff + 1'b1; state_in = delete_ff ? S_ERD : S_BRD;
            end
         end
         // peeling round: node visit
         S_PRD: state_in = S_PCHK;
         S_PCHK: begin
            if (a_q && ({1'b0, d_q} < (DW+1)'(min_deg_ff))) begin
               a_we = 1'b1; a_wd = 1'b0; changed_in = 1'b1;
               if (alive_cnt_ff != '0) alive_cnt_in = alive_cnt_ff - 1'b1;
               ji_in = '0;
               state_in = (total_ff == '0) ? S_PNEXT : S_ERD;
            end else state_in = S_PNEXT;
         end
         S_ERD: state_in = S_ECHK;
         S_ECHK: begin
            if (el_q && (ea_q == cur_node || eb_q == cur_node)) begin
               el_we = 1'b1; el_wd = 1'b0; n_addr = NW'(ea_q);
               delete_in = 1'b1; state_in = S_DA;
            end else if (ji_ff + 1'b1 == total_ff) state_in = S_PNEXT;
            else begin
               ji_in = ji_ff + 1'b1; state_in = S_ERD;
            end
         end
         S_DA: begin
            n_addr = NW'(ea_q); d_we = 1'b1;
            d_wd = (d_q != '0) ? d_q - 1'b1 : d_q;
            state_in = S_DB;
         end
         S_DB: begin
            n_addr = NW'(eb_q); state_in = S_DB2;
         end
         S_PNEXT: begin
            if (vi_ff + 1'b1 == active_ff) begin
               if (changed_ff) begin
                  changed_in = 1'b0; vi_in = '0; state_in = S_PRD;
               end else state_in = S_OUT;
            end else begin
               vi_in = vi_ff + 1'b1; state_in = S_PRD;
            end
         end
         S_LCHK: begin
            if (ptr_ff == '0) begin
               rsp_valid_in = 1'b1; rsp_size_in = '0; rsp_end_in = '0;
               rsp_status_in = 1'b1; state_in = S_IDLE;
            end else if (active_ff == '0) state_in = S_OUT;
            else begin
               vi_in = '0; changed_in = 1'b0; state_in = S_PRD;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1; rsp_size_in = CfgWidth'(alive_cnt_ff);
            rsp_end_in = EdgeWidth'(ptr_ff - 1'b1); rsp_status_in = 1'b0;
            ptr_in = ptr_ff - 1'b1; ji_in = ptr_ff - 1'b1;
            vi_in = VW'(MAX_NODES); // marks the final deletion
            state_in = S_LRD;
         end
         S_LRD: state_in = S_PRD2;
         S_PRD2: begin
            if (el_q) begin
               el_we = 1'b1; el_wd = 1'b0; n_addr = NW'(ea_q);
               delete_in = 1'b1; state_in = S_DA2;
            end else state_in = S_IDLE;
         end
         S_DA2: begin
            n_addr = NW'(ea_q); d_we = 1'b1;
            d_wd = (d_q != '0) ? d_q - 1'b1 : d_q;
            state_in = S_DB;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; total_ff <= '0; ptr_ff <= '0; alive_cnt_ff <= '0;
         active_ff <= '0; started_ff <= 1'b0; changed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; delete_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; ptr_ff <= ptr_in; alive_cnt_ff <= alive_cnt_in;
         active_ff <= active_in; started_ff <= started_in; changed_ff <= changed_in;
         rsp_valid_ff <= rsp_valid_in; delete_ff <= delete_in;
      end
      vi_ff <= vi_in;
      ji_ff <= ji_in;
      rsp_size_ff <= rsp_size_in; rsp_end_ff <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_core_size  = rsp_size_ff;
   assign rsp_prefix_end = rsp_end_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef ASSERT_OFF
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
   a_alive_bound: assert property (@(posedge clock) disable iff (reset)
      alive_cnt_ff <= active_ff) else $error("alive count above node count");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_EDGES)) else $error("edge count beyond capacity");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_core_size == '0))
      else $error("empty report with nonzero size");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the k-core peeling block under edge deletion
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import okc_pkg::*;

   localparam int MaxNodes = 1024;
   localparam int MaxEdges = 4096;
   localparam int UsedNodes = 24;

   typedef struct packed {
      logic [CfgWidth-1:0]  core_size;
      logic [EdgeWidth-1:0] prefix_end;
      logic                 status;
   } core_report_type;

   typedef struct {
      logic                 mode;
      logic [NodeWidth-1:0] a;
      logic [NodeWidth-1:0] b;
   } edge_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = MODE_LOAD;
   logic [NodeWidth-1:0] req_node_a = '0;
   logic [NodeWidth-1:0] req_node_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [CfgWidth-1:0] rsp_core_size;
   logic [EdgeWidth-1:0] rsp_prefix_end;
   logic rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_MIN_DEGREE;
   logic [CfgWidth-1:0] csr_data = '0;

   offline_k_core_edge_deletion u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the peeling state
   logic [CfgWidth-1:0]  cfg_min_degree = 11'd0;
   logic [CfgWidth-1:0]  cfg_node_count = 11'd1024;
   logic [NodeWidth-1:0] sh_first [MaxEdges];
   logic [NodeWidth-1:0] sh_second[MaxEdges];
   logic                 sh_live  [MaxEdges];
   int unsigned          sh_degree[MaxNodes];
   logic                 sh_alive [MaxNodes];
   int unsigned sh_total = 0, sh_pointer = 0, sh_alive_count = 0, sh_active = 0;
   logic sh_started = 1'b0;

   core_report_type expected_reports[$];
   int err_count = 0;
   int reports_seen = 0;
   int loads_sent = 0;
   bit no_gaps = 1'b0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic void unlink_edge(input int unsigned j);
      sh_live[j] = 1'b0;
      if (sh_degree[sh_first[j]] > 0) sh_degree[sh_first[j]]--;
      if (sh_degree[sh_second[j]] > 0) sh_degree[sh_second[j]]--;
   endfunction

   function automatic core_report_type next_core_report();
      core_report_type r;
      bit changed;
      if (!sh_started) begin
         sh_started = 1'b1;
         sh_active = (cfg_node_count > MaxNodes) ? MaxNodes : cfg_node_count;
         sh_alive_count = sh_active;
         sh_pointer = sh_total;
         for (int v = 0; v < MaxNodes; v++) begin
            sh_degree[v] = 0;
            sh_alive[v] = (v < sh_active);
         end
         for (int j = 0; j < sh_total; j++) begin
            if (sh_first[j] < sh_active && sh_second[j] < sh_active
                && sh_first[j] != sh_second[j]) begin
               sh_live[j] = 1'b1;
               sh_degree[sh_first[j]]++;
               sh_degree[sh_second[j]]++;
            end else begin
               sh_live[j] = 1'b0;
            end
         end
      end
      if (sh_pointer == 0) begin
         r.core_size = '0;
         r.prefix_end = '0;
         r.status = 1'b1;
         return r;
      end
      changed = 1'b1;
      while (changed) begin
         changed = 1'b0;
         for (int v = 0; v < sh_active; v++) begin
            if (sh_alive[v] && sh_degree[v] < cfg_min_degree) begin
               for (int j = 0; j < sh_total; j++)
                  if (sh_live[j] && (sh_first[j] == v || sh_second[j] == v))
                     unlink_edge(j);
               sh_alive[v] = 1'b0;
               if (sh_alive_count > 0) sh_alive_count--;
               changed = 1'b1;
            end
         end
      end
      r.core_size = sh_alive_count[CfgWidth-1:0];
      r.prefix_end = EdgeWidth'(sh_pointer - 1);
      r.status = 1'b0;
      sh_pointer--;
      if (sh_live[sh_pointer]) unlink_edge(sh_pointer);
      return r;
   endfunction

   // accepted input words feed the shadow model
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_mode == MODE_LOAD) begin
            if (!sh_started && sh_total < MaxEdges) begin
               sh_first[sh_total] = req_node_a;
               sh_second[sh_total] = req_node_b;
               sh_live[sh_total] = 1'b0;
               sh_total++;
            end
         end else begin
            expected_reports = {expected_reports, next_core_report()};
         end
      end
   end

   // result side: check and random back-pressure
   int unsigned stall_left = 3;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report("unexpected result word", rsp_core_size, -1);
         end else begin
            core_report_type w;
            w = expected_reports.pop_front();
            if (rsp_core_size !== w.core_size) report("core_size", rsp_core_size, w.core_size);
            if (rsp_prefix_end !== w.prefix_end)
               report("prefix_end", rsp_prefix_end, w.prefix_end);
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
         end
         reports_seen++;
         stall_left = no_gaps ? 0 : $urandom_range(0, 13);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic send_word(input logic mode, input logic [NodeWidth-1:0] a,
                            input logic [NodeWidth-1:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_LOAD) loads_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CfgWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_DEGREE) cfg_min_degree = value;
      else cfg_node_count = value;
      @(posedge clock);
   endtask

   // extremes, self-loops, repeated and out-of-range edges
   edge_row_type load_rows[12] = '{
      '{MODE_LOAD, 10'd0, 10'd1}, '{MODE_LOAD, 10'd0, 10'd1},
      '{MODE_LOAD, 10'd1023, 10'd1023}, '{MODE_LOAD, 10'd0, 10'd0},
      '{MODE_LOAD, 10'd5, 10'd1023}, '{MODE_LOAD, 10'd1023, 10'd0},
      '{MODE_LOAD, 10'd1, 10'd2}, '{MODE_LOAD, 10'd2, 10'd0},
      '{MODE_LOAD, 10'd23, 10'd22}, '{MODE_LOAD, 10'd24, 10'd3},
      '{MODE_LOAD, 10'd682, 10'd341}, '{MODE_LOAD, 10'd3, 10'd23}
   };

   initial begin
      int md_steps[5] = '{2, 3, 0, 1, 1024};
      int a, b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // only the last node count before the first report counts
      csr_write(CSR_NODE_COUNT, 11'd0);
      csr_write(CSR_NODE_COUNT, 11'd2047);
      csr_write(CSR_NODE_COUNT, 11'd1);
      csr_write(CSR_NODE_COUNT, 11'd1024);
      csr_write(CSR_NODE_COUNT, 11'(UsedNodes));
      csr_write(CSR_MIN_DEGREE, 11'd1024);
      csr_write(CSR_MIN_DEGREE, 11'd2);

      foreach (load_rows[i]) send_word(load_rows[i].mode, load_rows[i].a, load_rows[i].b);

      // mostly well-formed edges among the used nodes, some noise
      for (int i = 0; i < 40; i++) begin
         no_gaps = (i >= 20 && i < 30);
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 1023);
            b = ($urandom_range(0, 1)) ? a : $urandom_range(0, 1023);
         end else begin
            a = $urandom_range(0, UsedNodes - 1);
            do b = $urandom_range(0, UsedNodes - 1); while (b == a);
         end
         send_word(MODE_LOAD, NodeWidth'(a), NodeWidth'(b));
      end
      no_gaps = 1'b0;
      settle();

      // reports in phases of min_degree, with ignored loads mixed in
      foreach (md_steps[p]) begin
         if (p > 0) csr_write(CSR_MIN_DEGREE, 11'(md_steps[p]));
         no_gaps = (p == 2);
         for (int i = 0; i < 16; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_word(MODE_LOAD, NodeWidth'($urandom_range(0, 1023)),
                         NodeWidth'($urandom_range(0, 1023)));
            send_word(MODE_REPORT, NodeWidth'($urandom_range(0, 1023)),
                      NodeWidth'($urandom_range(0, 1023)));
         end
         settle();
      end
      no_gaps = 1'b0;
      // prefix is now empty, these give the no-edges status
      repeat (4) send_word(MODE_REPORT, 10'd1023, 10'd1023);
      settle();
      repeat (50) @(posedge clock);

      $display("%0d edge words sent, %0d reports checked over five core thresholds",
               loads_sent, reports_seen);
      if (err_count == 0 && expected_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
